// File: hw/rtl/chd_pkg.sv
// Shared types and constants for the chained hash dictionary.
package chd_pkg;
    localparam int MAX_BUCKETS = 1024;
    localparam int POOL_NODES  = 4096;
    localparam int BK_W        = $clog2(MAX_BUCKETS);
    localparam int NODE_W      = $clog2(POOL_NODES) + 1;
    localparam int IDX_W       = NODE_W - 1;
    localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL_NODES);
    localparam int BCNT_W      = 11;
    localparam int CODE_W      = 31;
    localparam int CFG_IDX_W   = 1;
    localparam logic [24:0] CNT_MAX = 25'h1ffffff;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 1'b1;

    typedef enum logic [2:0] {
        OP_SEEK   = 3'd0,
        OP_MODIFY = 3'd1,
        OP_DELETE = 3'd2,
        OP_ADD    = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_BAD_OP    = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]      op;
        logic [31:0]     key_a;
        logic [31:0]     key_b;
        logic [31:0]     code;
        logic [31:0]     other;
        logic [BK_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic              load;
        logic [CODE_W-1:0] value;
    } t_code_load;
endpackage

// File: hw/rtl/chd_front.sv
// Front end: accepts words, folds the key sum into a bucket index.
module chd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [2:0]                i_operation,
    input  logic [31:0]               i_key_a,
    input  logic [31:0]               i_key_b,
    input  logic [31:0]               i_entry_code,
    input  logic [31:0]               i_other_word,
    input  logic [chd_pkg::BCNT_W-1:0] i_bucket_count,
    output logic                      o_job_valid,
    input  logic                      i_job_full,
    output chd_pkg::t_job             o_job
);
    import chd_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate           r_state;
    t_job              r_job;
    logic [31:0]       r_sum;
    logic [BCNT_W-1:0] r_rem;
    logic [BCNT_W-1:0] r_div;
    logic [2:0]        r_cnt;
    logic [BCNT_W-1:0] n_rem;
    logic [BCNT_W-1:0] n_div;
    logic [BCNT_W:0]   t;

    // four restoring steps per cycle, remainder stays below the divisor
    always_comb begin
        n_rem = r_rem;
        t     = '0;
        for (int k = 0; k < 4; k++) begin
            t = {n_rem, r_sum[31-k]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[BCNT_W-1:0];
        end
    end

    always_comb begin
        if (i_bucket_count == '0) begin
            n_div = BCNT_W'(1);
        end else if (i_bucket_count > BCNT_W'(MAX_BUCKETS)) begin
            n_div = BCNT_W'(MAX_BUCKETS);
        end else begin
            n_div = i_bucket_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_job.op     <= i_operation;
                        r_job.key_a  <= i_key_a;
                        r_job.key_b  <= i_key_b;
                        r_job.code   <= i_entry_code;
                        r_job.other  <= i_other_word;
                        r_job.bucket <= '0;
                        r_sum        <= i_key_a + i_key_b;
                        r_div        <= n_div;
                        r_rem        <= '0;
                        r_cnt        <= '0;
                        r_state      <= (i_operation <= OP_ADD) ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    r_rem <= n_rem;
                    r_sum <= {r_sum[27:0], 4'd0};
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_job_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_full      = (r_state != F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    always_comb begin
        o_job        = r_job;
        o_job.bucket = r_rem[BK_W-1:0];
    end
endmodule

// File: hw/rtl/chd_queue.sv
// Two-entry job queue between front and back.
module chd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  chd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output chd_pkg::t_job o_job
);
    import chd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

// File: hw/rtl/chd_back.sv
// Back end: chain walk, node pool, free list and result register.
module chd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_empty,
    output logic                  o_job_pop,
    input  chd_pkg::t_job         i_job,
    input  chd_pkg::t_code_load   i_code_load,
    output logic                  o_init_busy,
    output logic                  o_valid,
    input  logic                  i_pop,
    output logic [1:0]            o_status,
    output logic [31:0]           o_code_out,
    output logic [31:0]           o_other_out,
    output logic [12:0]           o_entry_count
);
    import chd_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_HEAD, S_NODE, S_DEL, S_ALLOC, S_ADD
    } t_bstate;

    logic [NODE_W-1:0] head_mem [MAX_BUCKETS];
    logic [63:0]       key_mem  [POOL_NODES];
    logic [31:0]       code_mem [POOL_NODES];
    logic [31:0]       oth_mem  [POOL_NODES];
    logic [NODE_W-1:0] lnk_mem  [POOL_NODES];

    logic [NODE_W-1:0] hd_q;
    logic [63:0]       key_q;
    logic [31:0]       code_q;
    logic [31:0]       oth_q;
    logic [NODE_W-1:0] lnk_q;

    t_bstate           r_state;
    logic              r_init;
    logic [BK_W-1:0]   r_sweep;
    t_job              r_job;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] r_prev;
    logic [NODE_W-1:0] r_head;
    logic [NODE_W-1:0] r_free;
    logic [NODE_W-1:0] r_fresh;
    logic [NODE_W-1:0] r_nn;
    logic [CODE_W-1:0] r_next_code;
    logic [12:0]       r_count;
    logic              r_valid;
    logic [1:0]        r_status;
    logic [31:0]       r_code;
    logic [31:0]       r_other;
    logic [12:0]       r_out_cnt;

    // memory control
    logic [BK_W-1:0]   hd_ra;
    logic              hd_we;
    logic [BK_W-1:0]   hd_wa;
    logic [NODE_W-1:0] hd_wd;
    logic [IDX_W-1:0]  nd_ra;
    logic              nd_we;
    logic              oth_we;
    logic [IDX_W-1:0]  nd_wa;
    logic [31:0]       code_wd;
    logic [31:0]       oth_wd;
    logic              lk_we;
    logic [IDX_W-1:0]  lk_wa;
    logic [NODE_W-1:0] lk_wd;

    logic              key_hit;
    logic [24:0]       inc;
    logic [25:0]       cnt_sum;
    logic [31:0]       bump_other;
    logic              assign_code;
    logic [31:0]       new_code;
    logic [31:0]       new_other;

    assign key_hit = (key_q == {r_job.key_a, r_job.key_b});
    assign inc     = (r_job.other[24:0] == '0) ? 25'd1 : r_job.other[24:0];
    assign cnt_sum = {1'b0, oth_q[24:0]} + {1'b0, inc};
    assign bump_other = {oth_q[31:25], cnt_sum[25] ? CNT_MAX : cnt_sum[24:0]};
    assign assign_code = r_job.code[31];
    assign new_code  = assign_code ? {1'b0, r_next_code} : r_job.code;
    assign new_other = (assign_code && r_job.other[24:0] == '0)
                     ? {r_job.other[31:25], 25'd1} : r_job.other;

    always_comb begin
        hd_ra   = i_job.bucket;
        hd_we   = 1'b0;
        hd_wa   = r_job.bucket;
        hd_wd   = r_nn;
        nd_ra   = r_cur[IDX_W-1:0];
        nd_we   = 1'b0;
        oth_we  = 1'b0;
        nd_wa   = r_cur[IDX_W-1:0];
        code_wd = r_job.code;
        oth_wd  = r_job.other;
        lk_we   = 1'b0;
        lk_wa   = r_cur[IDX_W-1:0];
        lk_wd   = r_free;
        case (r_state)
            S_SWEEP: begin
                hd_we = 1'b1;
                hd_wa = r_sweep;
                hd_wd = NIL;
            end
            S_HEAD: begin
                if (hd_q == NIL) begin
                    nd_ra = r_free[IDX_W-1:0];
                end else begin
                    nd_ra = hd_q[IDX_W-1:0];
                end
            end
            S_NODE: begin
                if (key_hit) begin
                    if (r_job.op == OP_MODIFY) begin
                        nd_we  = 1'b1;
                        oth_we = 1'b1;
                    end else if (r_job.op == OP_ADD) begin
                        oth_we = 1'b1;
                        oth_wd = bump_other;
                    end else if (r_job.op == OP_DELETE) begin
                        if (r_prev == NIL) begin
                            hd_we = 1'b1;
                            hd_wd = lnk_q;
                        end else begin
                            lk_we = 1'b1;
                            lk_wa = r_prev[IDX_W-1:0];
                            lk_wd = lnk_q;
                        end
                    end
                end else if (lnk_q == NIL) begin
                    nd_ra = r_free[IDX_W-1:0];
                end else begin
                    nd_ra = lnk_q[IDX_W-1:0];
                end
            end
            S_DEL: begin
                lk_we = 1'b1;
            end
            S_ADD: begin
                nd_we   = 1'b1;
                oth_we  = 1'b1;
                nd_wa   = r_nn[IDX_W-1:0];
                code_wd = new_code;
                oth_wd  = new_other;
                lk_we   = 1'b1;
                lk_wa   = r_nn[IDX_W-1:0];
                lk_wd   = r_head;
                hd_we   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        hd_q <= head_mem[hd_ra];
        if (hd_we) head_mem[hd_wa] <= hd_wd;
    end

    always_ff @(posedge i_clk) begin
        key_q  <= key_mem[nd_ra];
        code_q <= code_mem[nd_ra];
        oth_q  <= oth_mem[nd_ra];
        lnk_q  <= lnk_mem[nd_ra];
        if (nd_we) begin
            key_mem[nd_wa]  <= {r_job.key_a, r_job.key_b};
            code_mem[nd_wa] <= code_wd;
        end
        if (oth_we) oth_mem[nd_wa] <= oth_wd;
        if (lk_we)  lnk_mem[lk_wa] <= lk_wd;
    end

    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_free      <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_next_code <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_pop && r_valid) r_valid <= 1'b0;
            if (i_code_load.load) r_next_code <= i_code_load.value;
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == BK_W'(MAX_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                        if (r_init) begin
                            r_init <= 1'b0;
                        end else begin
                            r_valid   <= 1'b1;
                            r_status  <= ST_OK;
                            r_code    <= '0;
                            r_other   <= '0;
                            r_out_cnt <= '0;
                        end
                    end
                end
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_job <= i_job;
                        if (i_job.op == OP_CLEAR) begin
                            r_sweep     <= '0;
                            r_free      <= NIL;
                            r_fresh     <= '0;
                            r_count     <= '0;
                            r_next_code <= '0;
                            r_state     <= S_SWEEP;
                        end else if (i_job.op > OP_CLEAR) begin
                            r_valid   <= 1'b1;
                            r_status  <= ST_BAD_OP;
                            r_code    <= '1;
                            r_other   <= '0;
                            r_out_cnt <= r_count;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    r_head <= hd_q;
                    r_cur  <= hd_q;
                    r_prev <= NIL;
                    r_state <= (hd_q == NIL) ? S_ALLOC : S_NODE;
                end
                S_NODE: begin
                    if (key_hit) begin
                        r_status  <= ST_OK;
                        r_out_cnt <= r_count;
                        if (r_job.op == OP_MODIFY) begin
                            r_code  <= r_job.code;
                            r_other <= r_job.other;
                        end else if (r_job.op == OP_ADD) begin
                            r_code  <= code_q;
                            r_other <= bump_other;
                        end else begin
                            r_code  <= code_q;
                            r_other <= oth_q;
                        end
                        // delete still has to push the node on the free list
                        if (r_job.op == OP_DELETE) begin
                            r_state <= S_DEL;
                        end else begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= lnk_q;
                        if (lnk_q == NIL) r_state <= S_ALLOC;
                    end
                end
                S_DEL: begin
                    r_free    <= r_cur;
                    r_count   <= r_count - 13'd1;
                    r_out_cnt <= r_count - 13'd1;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_ALLOC: begin
                    // miss; link word of the free head was read last cycle
                    if (r_job.op != OP_ADD) begin
                        r_valid   <= 1'b1;
                        r_status  <= ST_NOT_FOUND;
                        r_code    <= '1;
                        r_other   <= '0;
                        r_out_cnt <= r_count;
                        r_state   <= S_IDLE;
                    end else if (r_free != NIL) begin
                        r_nn    <= r_free;
                        r_free  <= lnk_q;
                        r_state <= S_ADD;
                    end else if (r_fresh != NIL) begin
                        r_nn    <= r_fresh;
                        r_fresh <= r_fresh + 1'b1;
                        r_state <= S_ADD;
                    end else begin
                        r_valid   <= 1'b1;
                        r_status  <= ST_POOL_FULL;
                        r_code    <= '1;
                        r_other   <= '0;
                        r_out_cnt <= r_count;
                        r_state   <= S_IDLE;
                    end
                end
                S_ADD: begin
                    if (assign_code && r_next_code != '1) begin
                        r_next_code <= r_next_code + 1'b1;
                    end
                    r_count   <= r_count + 13'd1;
                    r_out_cnt <= r_count + 13'd1;
                    r_status  <= ST_OK;
                    r_code    <= new_code;
                    r_other   <= new_other;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_init_busy   = r_init;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_code_out    = r_code;
    assign o_other_out   = r_other;
    assign o_entry_count = r_out_cnt;
endmodule

// File: hw/rtl/chained_hash_dictionary_top.sv
// Top level of the chained hash dictionary.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  input    | push / full                 | operation, key_a, key_b, entry_code,
//           |                             | other_word
//  result   | empty / pop                 | status, code_out, other_out, entry_count
//  config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Front takes a word and reduces key_a+key_b mod bucket_count (4 bits a cycle;
// clear and bad ops skip this); a 2-word queue then feeds the back end.
// Back end: reads the chain head, walks the chain node by node, then frees the node
// on delete or allocates one on an add miss; one result register, back waits while
// it is full. Clear sweeps all 1024 bucket heads, 1 per cycle; after reset the same
// sweep runs with full held high. Config writes are always ready; each lands in a
// register (bucket count, or next code to assign).
module chained_hash_dictionary_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [2:0]                        i_operation,
    input  logic [31:0]                       i_key_a,
    input  logic [31:0]                       i_key_b,
    input  logic signed [31:0]                i_entry_code,
    input  logic [31:0]                       i_other_word,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_status,
    output logic signed [31:0]                o_code_out,
    output logic [31:0]                       o_other_out,
    output logic [12:0]                       o_entry_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [chd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import chd_pkg::*;

    logic [BCNT_W-1:0] r_bucket_count;
    t_code_load        code_load;
    logic              cfg_wr;
    logic              front_full;
    logic              init_busy;
    logic              job_valid;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    t_job              front_job;
    t_job              q_job;
    logic              res_valid;
    logic [31:0]       code_bits;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BCNT_W'(MAX_BUCKETS);
        end else if (cfg_wr && i_cfg_index == REG_BUCKET_COUNT) begin
            r_bucket_count <= i_cfg_data[BCNT_W-1:0];
        end
    end

    // first_code has no other use than reloading the next code to assign
    assign code_load.load  = cfg_wr && (i_cfg_index == REG_FIRST_CODE);
    assign code_load.value = i_cfg_data[CODE_W-1:0];

    assign full = front_full | init_busy;

    chd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push && !init_busy),
        .o_full         (front_full),
        .i_operation    (i_operation),
        .i_key_a        (i_key_a),
        .i_key_b        (i_key_b),
        .i_entry_code   (i_entry_code),
        .i_other_word   (i_other_word),
        .i_bucket_count (r_bucket_count),
        .o_job_valid    (job_valid),
        .i_job_full     (q_full),
        .o_job          (front_job)
    );

    chd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .o_full  (q_full),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    chd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (q_empty),
        .o_job_pop     (q_pop),
        .i_job         (q_job),
        .i_code_load   (code_load),
        .o_init_busy   (init_busy),
        .o_valid       (res_valid),
        .i_pop         (pop),
        .o_status      (o_status),
        .o_code_out    (code_bits),
        .o_other_out   (o_other_out),
        .o_entry_count (o_entry_count)
    );

    assign o_code_out = signed'(code_bits);
    assign empty      = !res_valid;
endmodule

// File: hw/rtl/chd_checker.sv
// Port-level checks for the chained hash dictionary, bound to the top.
module chd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [31:0] o_code_out,
    input logic [31:0] o_other_out
);
    import chd_pkg::*;

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && full)
        else $error("result or input side open right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> o_code_out == 32'hffffffff)
        else $error("failed operation without code -1");

    a_fail_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> o_other_out == '0)
        else $error("failed operation with nonzero other word");
endmodule

bind chained_hash_dictionary_top chd_checker u_chd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_status    (o_status),
    .o_code_out  (o_code_out),
    .o_other_out (o_other_out)
);

// File: tb/dictionary_checker.sv
`timescale 1ns / 100ps
// Reply predictor and scoreboard for the chained hash dictionary.
module dictionary_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [2:0]                    i_operation,
    input  logic [31:0]                   i_key_a,
    input  logic [31:0]                   i_key_b,
    input  logic signed [31:0]            i_entry_code,
    input  logic [31:0]                   i_other_word,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [1:0]                    o_status,
    input  logic signed [31:0]            o_code_out,
    input  logic [31:0]                   o_other_out,
    input  logic [12:0]                   o_entry_count,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [chd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_waiting,
    output int                            o_replies,
    output int                            o_pool_full_seen
);
    import chd_pkg::*;

    localparam int unsigned NONE = POOL_NODES;
    localparam logic [31:0] COUNT_MASK = 32'h01ff_ffff;
    localparam logic [31:0] FLAG_MASK  = 32'hfe00_0000;

    typedef struct packed {
        t_status     st;
        logic [31:0] code;
        logic [31:0] other;
        logic [12:0] cnt;
    } t_reply;

    t_reply      expected_replies[$];
    logic [63:0] node_key[POOL_NODES];
    logic [31:0] node_code[POOL_NODES];
    logic [31:0] node_other[POOL_NODES];
    int unsigned node_next[POOL_NODES];
    int unsigned chain_head[MAX_BUCKETS];
    int unsigned free_top;
    int unsigned fresh_top;
    int unsigned stored;
    logic [30:0] next_code;
    logic [10:0] bucket_reg;

    initial begin
        o_fail_count = 0;
        o_waiting = 0;
        o_replies = 0;
        o_pool_full_seen = 0;
    end

    function automatic void empty_table();
        for (int i = 0; i < MAX_BUCKETS; i++) chain_head[i] = NONE;
        free_top = NONE;
        fresh_top = 0;
        stored = 0;
    endfunction

    // Applies one word to the shadow table and returns the reply it should give.
    function automatic t_reply lookup_and_update(logic [2:0] op, logic [31:0] a,
                                                 logic [31:0] b, logic [31:0] code,
                                                 logic [31:0] other);
        t_reply      r;
        logic [63:0] key;
        logic [31:0] sum;
        int unsigned n, bk, cur, prev, steps, nn, inc, cnt;
        bit          found;
        key = {a, b};
        r.st = ST_BAD_OP;
        r.code = '1;
        r.other = '0;
        if (op == OP_CLEAR) begin
            empty_table();
            next_code = '0;
            r.st = ST_OK;
            r.code = '0;
        end else if (op <= OP_ADD) begin
            n = 32'(bucket_reg);
            if (n == 0) n = 1;
            if (n > MAX_BUCKETS) n = MAX_BUCKETS;
            sum = a + b;
            bk = sum % n;
            cur = chain_head[bk];
            prev = NONE;
            steps = 0;
            while (cur < NONE && steps < POOL_NODES && node_key[cur] != key) begin
                prev = cur;
                cur = node_next[cur];
                steps++;
            end
            found = (cur < NONE) && (node_key[cur] == key);
            if (op != OP_ADD) begin
                if (!found) begin
                    r.st = ST_NOT_FOUND;
                end else begin
                    if (op == OP_MODIFY) begin
                        node_code[cur] = code;
                        node_other[cur] = other;
                    end else if (op == OP_DELETE) begin
                        if (prev == NONE) chain_head[bk] = node_next[cur];
                        else node_next[prev] = node_next[cur];
                        node_next[cur] = free_top;
                        free_top = cur;
                        if (stored > 0) stored--;
                    end
                    r.st = ST_OK;
                    r.code = node_code[cur];
                    r.other = node_other[cur];
                end
            end else if (found) begin
                // counter bump, saturating, flags kept
                inc = other & COUNT_MASK;
                if (inc == 0) inc = 1;
                cnt = node_other[cur] & COUNT_MASK;
                cnt = (cnt > COUNT_MASK - inc) ? COUNT_MASK : cnt + inc;
                node_other[cur] = (node_other[cur] & FLAG_MASK) | cnt;
                r.st = ST_OK;
                r.code = node_code[cur];
                r.other = node_other[cur];
            end else begin
                if (free_top < NONE) begin
                    nn = free_top;
                    free_top = node_next[nn];
                end else if (fresh_top < NONE) begin
                    nn = fresh_top;
                    fresh_top++;
                end else begin
                    nn = NONE;
                end
                if (nn == NONE) begin
                    r.st = ST_POOL_FULL;
                end else begin
                    if (code[31]) begin
                        code = {1'b0, next_code};
                        if ((other & COUNT_MASK) == 0) other = (other & FLAG_MASK) + 1;
                        if (next_code != '1) next_code++;
                    end
                    node_key[nn] = key;
                    node_code[nn] = code;
                    node_other[nn] = other;
                    node_next[nn] = chain_head[bk];
                    chain_head[bk] = nn;
                    stored++;
                    r.st = ST_OK;
                    r.code = code;
                    r.other = other;
                end
            end
        end
        r.cnt = 13'(stored);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s at reply %0d: got %h, expected %h",
                 $realtime, what, o_replies, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            empty_table();
            bucket_reg = 11'd1024;
            next_code = '0;
            expected_replies.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_BUCKET_COUNT: bucket_reg = i_cfg_data[10:0];
                    REG_FIRST_CODE:   next_code = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (push && !full)
                expected_replies.push_back(lookup_and_update(i_operation, i_key_a,
                                           i_key_b, i_entry_code, i_other_word));
            if (pop && !empty) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected word", 32'(o_status), 32'd0);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.st)
                        report_mismatch("status", 32'(o_status), 32'(want.st));
                    if (o_code_out !== want.code) report_mismatch("code", o_code_out, want.code);
                    if (o_other_out !== want.other)
                        report_mismatch("other word", o_other_out, want.other);
                    if (o_entry_count !== want.cnt)
                        report_mismatch("entry count", 32'(o_entry_count), 32'(want.cnt));
                    if (want.st == ST_POOL_FULL) o_pool_full_seen++;
                end
                o_replies++;
            end
        end
        o_waiting = expected_replies.size();
    end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the chained hash dictionary.
module testbench;
    import chd_pkg::*;

    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int BURST_ADDS  = 160;   // adds sent while the receiver holds off
    localparam int PHASE_WORDS = 185;   // random words per setting
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST  = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [2:0]            i_operation = '0;
    logic [31:0]           i_key_a = '0;
    logic [31:0]           i_key_b = '0;
    logic signed [31:0]    i_entry_code = '0;
    logic [31:0]           i_other_word = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            o_status;
    logic signed [31:0]    o_code_out;
    logic [31:0]           o_other_out;
    logic [12:0]           o_entry_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [31:0]           i_cfg_data = '0;

    int  fail_count, waiting, replies, pool_full_seen;
    bit  tx_fast = 1'b0;     // sender never idles
    bit  rx_fast = 1'b0;     // receiver never stalls
    bit  hold_req = 1'b0;    // asks the receiver for one long hold-off
    int  settings_run = 0;

    // small key set per phase so that hits, chains and deletes are common
    logic [31:0] set_a[16];
    logic [31:0] set_b[16];

    always #5 i_clk = ~i_clk;

    chained_hash_dictionary_top dut (.*);

    dictionary_checker checker_i (
        .*,
        .o_fail_count     (fail_count),
        .o_waiting        (waiting),
        .o_replies        (replies),
        .o_pool_full_seen (pool_full_seen)
    );

    // Sends one word: optional idle gap, then holds push until accepted.
    // push stays high on return so back-to-back words keep it up.
    task automatic send_word(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                             logic [31:0] code, logic [31:0] other);
        int gap;
        gap = (tx_fast || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_operation = op;
        i_key_a = a;
        i_key_b = b;
        i_entry_code = code;
        i_other_word = other;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender pauses until every reply is back, then idles before returning.
    task automatic drain();
        push = 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_word();
        int          pick, k;
        logic [2:0]  op;
        logic [31:0] a, b, code, other;
        pick = $urandom_range(0, 99);
        if (pick < 35)      op = OP_ADD;
        else if (pick < 55) op = OP_SEEK;
        else if (pick < 72) op = OP_MODIFY;
        else if (pick < 95) op = OP_DELETE;
        else if (pick < 96) op = OP_CLEAR;
        else                op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        k = $urandom_range(0, 15);
        a = set_a[k];
        b = set_b[k];
        if ($urandom_range(0, 7) == 0) begin
            a = $urandom;
            b = $urandom;
        end
        code = $urandom;
        if ($urandom_range(0, 2) == 0) code = '1;
        other = $urandom;
        case ($urandom_range(0, 3))
            0: other[24:0] = '0;
            1: other[24:0] = 25'h1ffffff - 25'($urandom_range(0, 15));
            default: ;
        endcase
        send_word(op, a, b, code, other);
    endtask

    // Receiver: random stalls per word, one long hold-off on request.
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = (rx_fast || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            @(posedge i_clk);
            while (empty !== 1'b0) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [31:0] bcount_set[6];
        logic [31:0] code_set[6];
        bcount_set = '{32'd1, 32'd2047, 32'd7, 32'd1024, 32'd0, 32'($urandom_range(2, 1023))};
        code_set   = '{32'h7fffffff, 32'd0, 32'd5, 32'h7ffffff0, 32'd1, 32'($urandom)};

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: one bucket (0 acts as 1), codes right below saturation.
        write_reg(REG_BUCKET_COUNT, 32'd0);
        write_reg(REG_FIRST_CODE, 32'h7ffffffe);
        send_word(OP_ADD, 32'h0, 32'h0, '1, 32'h0);                 // assigned code, counter 1
        send_word(OP_ADD, '1, '1, '1, 32'hfe000000);                // flags plus 1
        send_word(OP_ADD, 32'h12345678, 32'h9abcdef0, 32'h80000000, 32'h80000005); // code saturates
        send_word(OP_ADD, '1, '1, 32'h0, 32'h01ffffff);             // counter saturates
        send_word(OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0);              // bump by one
        send_word(OP_ADD, 32'h1, 32'h2, 32'h12345678, '1);          // explicit code
        send_word(OP_SEEK, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_SEEK, 32'h5, 32'h5, 32'h0, 32'h0);             // miss
        send_word(OP_MODIFY, 32'h12345678, 32'h9abcdef0, 32'h7fffffff, 32'h0);
        send_word(OP_MODIFY, 32'h6, 32'h6, 32'h1, 32'h1);           // miss
        send_word(OP_DELETE, 32'h1, 32'h2, 32'h0, 32'h0);           // chain head
        send_word(OP_DELETE, '1, '1, 32'h0, 32'h0);                 // mid chain
        send_word(OP_DELETE, '1, '1, 32'h0, 32'h0);                 // already gone
        send_word(OP_ADD, 32'h7, 32'h8, 32'h80000000, 32'h0);       // reuses freed node
        send_word(OP_BAD_FIRST, $urandom, $urandom, $urandom, $urandom);
        send_word(3'd6, $urandom, $urandom, $urandom, $urandom);
        send_word(OP_BAD_LAST, '1, '1, '1, '1);
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(OP_SEEK, 32'h0, 32'h0, 32'h0, 32'h0);             // gone after clear
        send_word(OP_ADD, 32'h0, 32'h0, '1, 32'h0);                 // code restarts at 0
        drain();

        // Burst of adds with no idle; receiver holds off meanwhile.
        write_reg(REG_BUCKET_COUNT, 32'd1024);
        write_reg(REG_FIRST_CODE, 32'd0);
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
        tx_fast = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < BURST_ADDS; i++)
            send_word(OP_ADD, 32'(i), $urandom, (i % 3 == 0) ? $urandom : '1, $urandom);
        send_word(OP_ADD, 32'hffff0000, 32'h1, '1, 32'h0);          // new key
        send_word(OP_SEEK, 32'h5, 32'h0, 32'h0, 32'h0);
        send_word(OP_ADD, 32'h5, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 3; i++) send_word(OP_DELETE, 32'(i * 100), $urandom, 0, 0);
        for (int i = 0; i < 4; i++) send_word(OP_ADD, 32'hffff0000 + 32'(i), 32'h3, '1, 0);
        tx_fast = 1'b0;
        drain();
        send_word(OP_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        // Random phases; table contents carry over across divisor changes.
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_BUCKET_COUNT, bcount_set[p]);
            write_reg(REG_FIRST_CODE, code_set[p]);
            settings_run++;
            for (int k = 0; k < 16; k++) begin
                set_a[k] = $urandom;
                set_b[k] = (k < 4) ? 32'(k) - set_a[k] : $urandom;   // key sum is k, from 0 to 3
            end
            tx_fast = (p == 2);
            rx_fast = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++) random_word();
            drain();
        end

        $display("checked %0d replies over %0d random settings plus directed cases,",
                 replies, settings_run);
        $display("burst of %0d adds under a %0d-cycle receiver hold-off, %0d pool-full replies",
                 BURST_ADDS, HOLD_CYCLES, pool_full_seen);
        if (fail_count == 0) begin
            $display("[chained_hash_dictionary_top] OK");
        end else begin
            $display("[chained_hash_dictionary_top] ERROR");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d replies outstanding", waiting);
        $display("[chained_hash_dictionary_top] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/chd_pkg.sv
hw/rtl/chd_front.sv
hw/rtl/chd_queue.sv
hw/rtl/chd_back.sv
hw/rtl/chained_hash_dictionary_top.sv
hw/rtl/chd_checker.sv
tb/dictionary_checker.sv
tb/testbench.sv
